// ===== hdl/mrlp_pkg.sv =====
// ----------------------------------------------------------------------------
// mrlp_pkg
// Shared types and character codes for the modem response line parser.
// ----------------------------------------------------------------------------
package mrlp_pkg;

  // Action codes carried with each input item
  typedef enum logic [1:0] {
    ACT_RX      = 2'd0,
    ACT_START   = 2'd1,
    ACT_RELEASE = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  // Characters of interest
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_PROMPT = 8'h3E;
  localparam logic [7:0] CH_O      = 8'h4F;
  localparam logic [7:0] CH_K      = 8'h4B;

  // Unsolicited message header "CMT", newest byte in the low bits
  localparam logic [23:0] HDR_MATCH = 24'h434D54;

  localparam logic [1:0] CNT_MAX = 2'd3;

  // One result item
  typedef struct packed {
    logic sms_pending;
    logic capture_active;
    logic prompt_found;
    logic ok_found;
    logic capture_done;
  } result_t;

endpackage

// ===== hdl/mrlp_core.sv =====
// ----------------------------------------------------------------------------
// mrlp_core
// Parser state registers and the single-pass update for one item.
// ----------------------------------------------------------------------------
module mrlp_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  mrlp_pkg::action_t action,
  input  logic [7:0]        rx_byte,
  output mrlp_pkg::result_t result
);
  import mrlp_pkg::*;

  logic [7:0]  last_byte, last_byte_next;
  logic        capturing, capturing_next;
  logic [1:0]  crlf_count, crlf_count_next;
  logic        ok_seen, ok_seen_next;
  logic        prev_captured_o, prev_captured_o_next;
  logic        prompt_seen, prompt_seen_next;
  logic [23:0] header_window, header_window_next;
  logic [1:0]  window_count, window_count_next;
  logic        header_seen, header_seen_next;
  logic        message_flag, message_flag_next;
  logic        done;
  logic        crlf;
  logic [1:0]  crlf_bumped;

  assign crlf        = (last_byte == CH_CR) && (rx_byte == CH_LF);
  assign crlf_bumped = (crlf_count == CNT_MAX) ? crlf_count : crlf_count + 2'd1;

  // Next-state logic for one item
  always_comb begin
    last_byte_next       = last_byte;
    capturing_next       = capturing;
    crlf_count_next      = crlf_count;
    ok_seen_next         = ok_seen;
    prev_captured_o_next = prev_captured_o;
    prompt_seen_next     = prompt_seen;
    header_window_next   = header_window;
    window_count_next    = window_count;
    header_seen_next     = header_seen;
    message_flag_next    = message_flag;
    done                 = 1'b0;
    unique case (action)
      ACT_START: begin
        last_byte_next       = 8'd0;
        crlf_count_next      = 2'd0;
        capturing_next       = 1'b1;
        ok_seen_next         = 1'b0;
        prev_captured_o_next = 1'b0;
        prompt_seen_next     = 1'b0;
      end
      ACT_RELEASE: begin
        message_flag_next  = 1'b0;
        header_seen_next   = 1'b0;
        window_count_next  = 2'd0;
        header_window_next = 24'd0;
        last_byte_next     = 8'd0;
      end
      ACT_RX: begin
        last_byte_next = rx_byte;
        if (capturing) begin
          if (crlf_count == 2'd2) begin
            // Inside the reply line
            if (prev_captured_o && rx_byte == CH_K) ok_seen_next = 1'b1;
            prev_captured_o_next = (rx_byte == CH_O);
            if (rx_byte == CH_PROMPT) prompt_seen_next = 1'b1;
            if (rx_byte == CH_LF || rx_byte == CH_PROMPT) begin
              capturing_next = 1'b0;
              done           = 1'b1;
            end
          end else if (crlf) begin
            crlf_count_next = crlf_bumped;
          end
        end else if (!message_flag) begin
          // Header watch outside capture
          header_window_next = {header_window[15:0], rx_byte};
          window_count_next  = (window_count == CNT_MAX) ? window_count
                                                         : window_count + 2'd1;
          if (!header_seen) begin
            if (window_count_next == CNT_MAX && header_window_next == HDR_MATCH) begin
              header_seen_next  = 1'b1;
              window_count_next = 2'd0;
              crlf_count_next   = 2'd0;
            end
          end else begin
            if (crlf) crlf_count_next = crlf_bumped;
            if (crlf_count_next > 2'd1) message_flag_next = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Result taken after the update
  always_comb begin
    result.capture_done   = done;
    result.ok_found       = ok_seen_next;
    result.prompt_found   = prompt_seen_next;
    result.capture_active = capturing_next;
    result.sms_pending    = message_flag_next;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      last_byte       <= 8'd0;
      capturing       <= 1'b0;
      crlf_count      <= 2'd0;
      ok_seen         <= 1'b0;
      prev_captured_o <= 1'b0;
      prompt_seen     <= 1'b0;
      header_window   <= 24'd0;
      window_count    <= 2'd0;
      header_seen     <= 1'b0;
      message_flag    <= 1'b0;
    end else if (en) begin
      last_byte       <= last_byte_next;
      capturing       <= capturing_next;
      crlf_count      <= crlf_count_next;
      ok_seen         <= ok_seen_next;
      prev_captured_o <= prev_captured_o_next;
      prompt_seen     <= prompt_seen_next;
      header_window   <= header_window_next;
      window_count    <= window_count_next;
      header_seen     <= header_seen_next;
      message_flag    <= message_flag_next;
    end
  end

  // Checks
  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    en && action == ACT_START |=> capturing && !ok_seen && !prompt_seen)
    else $error("start did not open a clean capture");

  a_release_clears: assert property (@(posedge clk) disable iff (rst)
    en && action == ACT_RELEASE |=> !message_flag && !header_seen)
    else $error("release did not clear the pending message");

  a_done_ends_capture: assert property (@(posedge clk) disable iff (rst)
    result.capture_done |-> capturing && !result.capture_active)
    else $error("capture end reported while not ending capture");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable({capturing, crlf_count, header_seen, message_flag, last_byte}))
    else $error("parser state moved without an item");

endmodule

// ===== hdl/modem_response_line_parser.sv =====
// ----------------------------------------------------------------------------
// modem_response_line_parser
// Byte-wise modem reply parser: reply capture with OK/prompt detection and
// unsolicited message header watch, with input and result registers.
// ----------------------------------------------------------------------------
// An accepted item passes the input register, then the result register,
// waiting in the input register on a stall. Throughput: one item per cycle
// when m_tready does not stall; the parser state updates once per item.
// Reset (rst, synchronous) clears all parser state and both stage valids.
module modem_response_line_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // [1:0] action, [9:2] rx_byte, [15:10] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata   // [0] capture_done, [1] ok_found,
                                // [2] prompt_found, [3] capture_active,
                                // [4] sms_pending, [7:5] zero
);
  import mrlp_pkg::*;

  logic       in_valid;
  action_t    in_action;
  logic [7:0] in_byte;
  logic       advance;
  result_t    core_result;
  result_t    out_result;

  // An item moves into the result register when that register is free
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_action <= action_t'(s_tdata[1:0]);
      in_byte   <= s_tdata[9:2];
    end
  end

  mrlp_core u_core (
    .clk     (clk),
    .rst     (rst),
    .en      (advance),
    .action  (in_action),
    .rx_byte (in_byte),
    .result  (core_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= core_result;
    end
  end

  assign m_tdata = {3'b000, out_result.sms_pending, out_result.capture_active,
                    out_result.prompt_found, out_result.ok_found,
                    out_result.capture_done};

endmodule
